>>> hw/rtl/nhvl_pkg.sv
package nhvl_pkg;

  localparam int TableEntries = 4096;
  localparam int NameLen = 16;
  localparam int AddrW = $clog2(TableEntries);
  localparam int FillW = $clog2(TableEntries + 1);
  localparam int CountW = $clog2(NameLen);

  localparam logic [31:0] CrcPreset = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  localparam logic OpWrite = 1'b0;
  localparam logic OpByte = 1'b1;

  localparam logic ResWrite = 1'b0;
  localparam logic ResLookup = 1'b1;

  localparam logic [1:0] OutMiss = 2'd0;
  localparam logic [1:0] OutLive = 2'd1;
  localparam logic [1:0] OutStale = 2'd2;

  localparam logic StatDone = 1'b0;
  localparam logic StatFull = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] kind;
    logic [7:0]  name_byte;
    logic        last_byte;
    logic [35:0] now_seconds;
    logic [31:0] entry_hash;
    logic [1:0]  entry_action;
    logic [31:0] entry_expiry;
    logic        entry_remove;
  } in_beat_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  verdict_action;
    logic [1:0]  lookup_outcome;
    logic [31:0] name_hash;
    logic        write_status;
  } out_beat_t;

  typedef struct packed {
    logic        is_lookup;
    logic [15:0] kind;
    logic [31:0] hash;
    logic [35:0] now;
    logic [1:0]  action;
    logic [31:0] expiry;
    logic        remove;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] key;
    logic [31:0] expiry;
    logic [1:0]  action;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/name_hash_verdict_lookup.sv
// name_hash_verdict_lookup: verdict table keyed by (kind, crc-32 of a name)
// in_data carries either a table write beat or one process name byte;
// out_data carries one result per write beat and one per last name byte.
// both channels are valid/ready; a beat moves when valid and ready are high.
// name bytes are hashed as they arrive; a non-last byte gives no result.
// writes and lookups pass through a two-deep queue to a table engine that
// scans the table memory one slot per cycle up to its fill mark, fill being
// the highest slot ever used plus one.
// removed slots below the fill mark are reused, lowest first.
// reset (rst, synchronous) clears the name hash state, the queue and the
// fill mark; the table memory needs no clearing pass.
// a stalled receiver holds the result register; the engine then waits and
// the queue fills, after which in_ready drops.
module name_hash_verdict_lookup import nhvl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t q_head;

  nhvl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  nhvl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  nhvl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/nhvl_ram.sv
module nhvl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/nhvl_queue.sv
module nhvl_queue import nhvl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hw/rtl/nhvl_front.sv
module nhvl_front import nhvl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  input  logic     q_full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic [31:0]       running_crc;
  logic [CountW-1:0] bytes_hashed;
  logic              hash_stopped;
  logic              take;
  logic              stop_now;
  logic [31:0]       crc_next;

  assign in_ready = !q_full;
  assign take = in_valid && in_ready;

  always_comb begin
    stop_now = (in_data.name_byte == 8'd0) ||
               ({{(32-CountW){1'b0}}, bytes_hashed} >= 32'(NameLen - 1));
    crc_next = running_crc;
    if (!hash_stopped && !stop_now) begin
      crc_next = crc_byte(running_crc, in_data.name_byte);
    end
  end

  always_comb begin
    push_cmd.is_lookup = (in_data.operation == OpByte);
    push_cmd.kind = in_data.kind;
    push_cmd.hash = (in_data.operation == OpByte) ? ~crc_next : in_data.entry_hash;
    push_cmd.now = in_data.now_seconds;
    push_cmd.action = in_data.entry_action;
    push_cmd.expiry = in_data.entry_expiry;
    push_cmd.remove = in_data.entry_remove;
    push = take && ((in_data.operation == OpWrite) || in_data.last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CrcPreset;
      bytes_hashed <= '0;
      hash_stopped <= 1'b0;
    end else if (take && in_data.operation == OpByte) begin
      if (in_data.last_byte) begin
        running_crc <= CrcPreset;
        bytes_hashed <= '0;
        hash_stopped <= 1'b0;
      end else if (!hash_stopped) begin
        if (stop_now) begin
          hash_stopped <= 1'b1;
        end else begin
          running_crc <= crc_next;
          bytes_hashed <= bytes_hashed + 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/nhvl_back.sv
module nhvl_back import nhvl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  cmd_t      q_head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t           state;
  cmd_t             cmd;
  logic [FillW-1:0] fill;
  logic [FillW-1:0] scan_idx;
  logic             rd_pend;
  logic [AddrW-1:0] rd_idx;
  logic             found;
  logic [AddrW-1:0] match_idx;
  slot_t            match_slot;
  logic             free_found;
  logic [AddrW-1:0] free_idx;

  logic             we;
  logic [AddrW-1:0] waddr;
  slot_t            wslot;
  slot_t            rslot;
  logic [SlotW-1:0] rdata;
  logic             can_finish;
  logic             write_full;
  logic             stale;

  assign rslot = slot_t'(rdata);
  assign pop = (state == IDLE) && !q_empty;
  assign can_finish = (state == FINISH) && (!out_valid || out_ready);
  assign stale = (match_slot.expiry != 32'd0) && ({4'd0, match_slot.expiry} <= cmd.now);

  always_comb begin
    we = 1'b0;
    waddr = match_idx;
    wslot.valid = 1'b1;
    wslot.key = {cmd.kind, cmd.hash};
    wslot.expiry = cmd.expiry;
    wslot.action = cmd.action;
    write_full = 1'b0;
    if (can_finish && !cmd.is_lookup) begin
      if (cmd.remove) begin
        we = found;
        wslot.valid = 1'b0;
      end else if (found) begin
        we = 1'b1;
      end else if (free_found) begin
        we = 1'b1;
        waddr = free_idx;
      end else if (fill < FillW'(TableEntries)) begin
        we = 1'b1;
        waddr = fill[AddrW-1:0];
      end else begin
        write_full = 1'b1;
      end
    end
  end

  nhvl_ram #(.Width(SlotW), .Depth(TableEntries)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wslot),
    .raddr (scan_idx[AddrW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      fill <= '0;
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !can_finish) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          rd_pend <= 1'b0;
          if (!q_empty) begin
            cmd <= q_head;
            scan_idx <= '0;
            found <= 1'b0;
            free_found <= 1'b0;
            state <= SCAN;
          end
        end
        SCAN: begin
          rd_pend <= (scan_idx < fill);
          rd_idx <= scan_idx[AddrW-1:0];
          if (scan_idx < fill) scan_idx <= scan_idx + 1'b1;
          if (rd_pend) begin
            if (rslot.valid && rslot.key == {cmd.kind, cmd.hash} && !found) begin
              found <= 1'b1;
              match_idx <= rd_idx;
              match_slot <= rslot;
            end
            if (!rslot.valid && !free_found) begin
              free_found <= 1'b1;
              free_idx <= rd_idx;
            end
          end
          if (scan_idx == fill && !rd_pend) state <= FINISH;
        end
        FINISH: begin
          if (can_finish) begin
            out_valid <= 1'b1;
            if (cmd.is_lookup) begin
              out_data.result_kind <= ResLookup;
              out_data.name_hash <= cmd.hash;
              out_data.write_status <= StatDone;
              out_data.lookup_outcome <= !found ? OutMiss : (stale ? OutStale : OutLive);
              out_data.verdict_action <= (found && !stale) ? match_slot.action : 2'd0;
            end else begin
              out_data.result_kind <= ResWrite;
              out_data.name_hash <= 32'd0;
              out_data.write_status <= write_full ? StatFull : StatDone;
              out_data.lookup_outcome <= OutMiss;
              out_data.verdict_action <= 2'd0;
            end
            if (we && !found && !free_found && !cmd.remove) fill <= fill + 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FillW'(TableEntries)) else $error("fill above table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == SCAN |-> scan_idx <= fill) else $error("scan past fill");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    can_finish && write_full |-> fill == FillW'(TableEntries))
    else $error("full reported with room left");

  a_fill_grow: assert property (@(posedge clk) disable iff (rst)
    fill != $past(fill) |-> $past(can_finish) && !$past(cmd.is_lookup))
    else $error("fill moved outside an insert");

endmodule

>>> bench/tb_name_hash_verdict_lookup.sv
`timescale 1ns / 100ps

module tb_name_hash_verdict_lookup;
  import nhvl_pkg::*;

  localparam int NumNames = 16;
  localparam int MaxName = 24;
  localparam int QuietLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;

  name_hash_verdict_lookup dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  in_beat_t beat_q[$];
  out_beat_t verdict_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  logic in_took = 1'b0;
  int errors = 0;
  int quiet = 0;
  int n_writes = 0, n_full = 0, n_lookups = 0, n_live = 0, n_stale = 0, n_miss = 0;

  // scoreboard copy of the table and name hasher
  logic [31:0] crc_run;
  logic [4:0]  n_hashed;
  logic        hash_done;
  logic        tbl_valid [TableEntries];
  logic [47:0] tbl_key [TableEntries];
  logic [1:0]  tbl_act [TableEntries];
  logic [31:0] tbl_exp [TableEntries];

  // stimulus pools
  logic [7:0]  names [NumNames][MaxName];
  int          name_len [NumNames];
  logic [15:0] kinds [4];
  logic [31:0] expiries [5];

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
    return r;
  endfunction

  function automatic logic [31:0] name_crc(int idx);
    logic [31:0] c;
    int cnt;
    c = CrcPreset;
    cnt = 0;
    for (int i = 0; i < name_len[idx]; i++) begin
      if (names[idx][i] == 8'd0 || cnt >= NameLen - 1) break;
      c = crc_step(c, names[idx][i]);
      cnt++;
    end
    return ~c;
  endfunction

  function automatic int find_entry(logic [47:0] key);
    for (int i = 0; i < TableEntries; i++)
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void predict_verdict(in_beat_t b);
    out_beat_t r;
    int s;
    logic [47:0] key;
    r = '0;
    if (b.operation == OpWrite) begin
      key = {b.kind, b.entry_hash};
      s = find_entry(key);
      n_writes++;
      r.result_kind = ResWrite;
      r.write_status = StatDone;
      if (b.entry_remove) begin
        if (s >= 0) tbl_valid[s] = 1'b0;
      end else begin
        if (s < 0)
          for (int i = 0; i < TableEntries; i++)
            if (!tbl_valid[i]) begin
              s = i;
              break;
            end
        if (s < 0) begin
          r.write_status = StatFull;
          n_full++;
        end else begin
          tbl_key[s] = key;
          tbl_act[s] = b.entry_action;
          tbl_exp[s] = b.entry_expiry;
          tbl_valid[s] = 1'b1;
        end
      end
      verdict_q.push_back(r);
      return;
    end
    if (!hash_done) begin
      if (b.name_byte == 8'd0 || n_hashed >= NameLen - 1) hash_done = 1'b1;
      else begin
        crc_run = crc_step(crc_run, b.name_byte);
        n_hashed++;
      end
    end
    if (!b.last_byte) return;
    r.result_kind = ResLookup;
    r.name_hash = ~crc_run;
    r.lookup_outcome = OutMiss;
    s = find_entry({b.kind, ~crc_run});
    n_lookups++;
    if (s < 0) n_miss++;
    else if (tbl_exp[s] != 32'd0 && {4'd0, tbl_exp[s]} <= b.now_seconds) begin
      r.lookup_outcome = OutStale;
      n_stale++;
    end else begin
      r.lookup_outcome = OutLive;
      r.verdict_action = tbl_act[s];
      n_live++;
    end
    verdict_q.push_back(r);
    crc_run = CrcPreset;
    n_hashed = '0;
    hash_done = 1'b0;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (beat_q.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
        in_data <= beat_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rst && ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk) begin
    out_beat_t e;
    in_took <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) predict_verdict(in_data);
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected beat: actual %h", $time, out_data);
          errors++;
        end else begin
          e = verdict_q.pop_front();
          if (e.result_kind != out_data.result_kind)
            $display("%0t result_kind: expected %0d actual %0d", $time, e.result_kind,
                     out_data.result_kind);
          if (e.verdict_action != out_data.verdict_action)
            $display("%0t verdict_action: expected %0d actual %0d", $time,
                     e.verdict_action, out_data.verdict_action);
          if (e.lookup_outcome != out_data.lookup_outcome)
            $display("%0t lookup_outcome: expected %0d actual %0d", $time,
                     e.lookup_outcome, out_data.lookup_outcome);
          if (e.name_hash != out_data.name_hash)
            $display("%0t name_hash: expected %h actual %h", $time, e.name_hash,
                     out_data.name_hash);
          if (e.write_status != out_data.write_status)
            $display("%0t write_status: expected %0d actual %0d", $time, e.write_status,
                     out_data.write_status);
          if (e != out_data) errors++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic in_beat_t noise_beat();
    in_beat_t b;
    logic [159:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    b = raw[$bits(in_beat_t)-1:0];
    return b;
  endfunction

  function automatic logic [35:0] rand_now();
    return {4'($urandom_range(15, 0)), 32'($urandom())};
  endfunction

  task automatic add_write(logic [15:0] kind, logic [31:0] hash, logic [1:0] act,
                           logic [31:0] expiry, logic remove);
    in_beat_t b;
    b = noise_beat();
    b.operation = OpWrite;
    b.kind = kind;
    b.entry_hash = hash;
    b.entry_action = act;
    b.entry_expiry = expiry;
    b.entry_remove = remove;
    beat_q.push_back(b);
  endtask

  task automatic add_name(int idx, logic [15:0] kind, logic [35:0] now, int mid_write);
    in_beat_t b;
    for (int i = 0; i < name_len[idx]; i++) begin
      if (i == mid_write)
        add_write(kinds[$urandom_range(3, 0)], $urandom(), 2'($urandom()), $urandom(),
                  1'b0);
      b = noise_beat();
      b.operation = OpByte;
      b.name_byte = names[idx][i];
      b.last_byte = (i == name_len[idx] - 1);
      if (b.last_byte) begin
        b.kind = kind;
        b.now_seconds = now;
      end
      beat_q.push_back(b);
    end
  endtask

  function automatic logic [35:0] pick_now();
    logic [31:0] x;
    x = expiries[$urandom_range(4, 0)];
    case ($urandom_range(5, 0))
      0: return {4'd0, x} - 36'd1;
      1: return {4'd0, x};
      2: return {4'd0, x} + 36'd1;
      3: return '1;
      4: return '0;
      default: return rand_now();
    endcase
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (beat_q.size() != 0 || in_valid || verdict_q.size() != 0);
  endtask

  task automatic random_items(int target);
    int r, idx;
    while (target > 0) begin
      r = $urandom_range(99, 0);
      idx = $urandom_range(NumNames - 1, 0);
      if (r < 30) begin
        add_write(kinds[$urandom_range(3, 0)], name_crc(idx), 2'($urandom()),
                  expiries[$urandom_range(4, 0)], $urandom_range(3, 0) == 0);
        target--;
      end else if (r < 35) begin
        add_write(16'($urandom()), $urandom(), 2'($urandom()), $urandom(),
                  $urandom_range(9, 0) < 3);
        target--;
      end else if (r < 90) begin
        add_name(idx, kinds[$urandom_range(3, 0)], pick_now(),
                 ($urandom_range(9, 0) == 0) ? $urandom_range(name_len[idx] - 1, 0) : -1);
        target -= name_len[idx];
      end else begin
        name_len[0] = $urandom_range(MaxName, 1);
        for (int i = 0; i < name_len[0]; i++) names[0][i] = 8'($urandom());
        add_name(0, 16'($urandom()), rand_now(), -1);
        target -= name_len[0];
        name_len[0] = 1;
        names[0][0] = 8'd0;
      end
    end
  endtask

  initial begin
    crc_run = CrcPreset;
    n_hashed = '0;
    hash_done = 1'b0;
    for (int i = 0; i < TableEntries; i++) tbl_valid[i] = 1'b0;
    kinds[0] = 16'h0000;
    kinds[1] = 16'hFFFF;
    kinds[2] = 16'($urandom());
    kinds[3] = 16'($urandom());
    expiries[0] = 32'd0;
    expiries[1] = 32'd1;
    expiries[2] = 32'd1000;
    expiries[3] = 32'hFFFF_FFFF;
    expiries[4] = $urandom();
    for (int n = 0; n < NumNames; n++) begin
      name_len[n] = $urandom_range(MaxName, 2);
      for (int i = 0; i < MaxName; i++) names[n][i] = 8'($urandom_range(255, 1));
    end
    // empty name, zero inside a name, longer than the hash cap, all-ones bytes
    name_len[0] = 1;
    names[0][0] = 8'd0;
    names[4][3] = 8'd0;
    name_len[3] = 20;
    for (int i = 0; i < name_len[5]; i++) names[5][i] = 8'hFF;
    names[6][name_len[6] - 1] = 8'd0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_name(0, 16'h0000, '0, -1);
    add_write(16'hFFFF, name_crc(1), 2'd3, 32'd0, 1'b0);
    add_name(1, 16'hFFFF, '1, -1);
    add_write(16'h0000, name_crc(2), 2'd2, 32'd1000, 1'b0);
    add_name(2, 16'h0000, 36'd999, -1);
    add_name(2, 16'h0000, 36'd1000, -1);
    add_write(16'h0000, name_crc(2), 2'd1, 32'hFFFF_FFFF, 1'b0);
    add_name(2, 16'h0000, 36'hF_FFFF_FFFE, -1);
    add_name(2, 16'h0000, 36'hF_FFFF_FFFF, -1);
    add_write(16'h1234, 32'hDEAD_BEEF, 2'd2, 32'd5, 1'b1);
    add_write(16'hFFFF, name_crc(1), 2'd0, 32'd7, 1'b1);
    add_name(1, 16'hFFFF, '0, -1);
    add_write(16'hFFFF, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF, 1'b0);
    add_write(16'h0000, 32'h0000_0000, 2'd0, 32'd0, 1'b0);
    add_write(16'h0000, name_crc(3), 2'd1, 32'd0, 1'b0);
    add_name(3, 16'h0000, rand_now(), 5);
    add_write(16'h0000, name_crc(4), 2'd2, 32'd0, 1'b0);
    add_name(4, 16'h0000, rand_now(), -1);
    add_name(6, 16'h0000, rand_now(), -1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 68 : (ph == 3) ? 17 : 0;
      stall_pct = (ph == 2) ? 68 : (ph == 3) ? 17 : 0;
      random_items(290);
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
    repeat (100) @(posedge clk);

    $display("covered %0d table writes (%0d refused full) and %0d lookups", n_writes,
             n_full, n_lookups);
    $display("lookups: %0d live hits, %0d stale, %0d misses", n_live, n_stale, n_miss);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
